// ===== design/xcfr_pkg.sv =====
package xcfr_pkg;

   localparam int BANK_BYTES_DEF   = 256;
   localparam int HEADER_BYTES_DEF = 8;
   localparam int LEN_W            = 9;

   localparam logic [7:0] START_BYTE_RST = 8'hFC;

   // request codes
   localparam logic [1:0] REQ_BYTE  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   // result event codes
   localparam logic [2:0] EV_IGNORED = 3'd0;
   localparam logic [2:0] EV_TAKEN   = 3'd1;
   localparam logic [2:0] EV_GOOD    = 3'd2;
   localparam logic [2:0] EV_BAD_SUM = 3'd3;
   localparam logic [2:0] EV_LEN_ERR = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEAD,
      PH_LOAD,
      PH_SUM
   } phase_type;

endpackage

// ===== design/xcfr_req_if.sv =====
interface xcfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] rx_byte;
   logic [7:0] read_index;

   modport source (output valid, output req_type, output rx_byte, output read_index,
                   input ready);
   modport sink (input valid, input req_type, input rx_byte, input read_index,
                 output ready);
endinterface

// ===== design/xcfr_rsp_if.sv =====
interface xcfr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [2:0]                event_res;
   logic                      frame_ready;
   logic [xcfr_pkg::LEN_W-1:0] frame_length;
   logic [7:0]                read_data;

   modport source (output valid, output event_res, output frame_ready,
                   output frame_length, output read_data, input ready);
   modport sink (input valid, input event_res, input frame_ready,
                 input frame_length, input read_data, output ready);
endinterface

// ===== design/xcfr_frame_ram.sv =====
module xcfr_frame_ram #(
   parameter int DEPTH  = 2 * xcfr_pkg::BANK_BYTES_DEF,
   parameter int ADDR_W = $clog2(2 * xcfr_pkg::BANK_BYTES_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/xor_checked_frame_receiver_top.sv =====
// Frame receiver with XOR checksum.
// req_chan carries one request per transfer: a received serial byte, a read of
// a byte of the completed frame, or a clear of the ready flag. rsp_chan returns
// exactly one result per request: event code, ready flag, length of the last
// good frame and the read byte (0 for other requests or beyond the frame).
// csr_wr_en/csr_wr_data set the start byte that opens a frame.
// Frames fill one half of a dual-bank byte RAM while the other half holds the
// last good frame; a good checksum swaps the halves.
// The result is registered and valid in the cycle after the request transfer; one
// request is taken every cycle while rsp_chan is not stalled. The frame parser
// updates its state and does at most one RAM write per accepted request, while a
// read of the completed bank uses the registered RAM read port in the same cycle.
// Reset clears parser state, ready flag and length and sets the start byte to
// 0xFC; RAM contents are not cleared. When rsp_chan stalls the result holds in
// the output register and req_chan.ready drops until the result is taken.
module xor_checked_frame_receiver_top #(
   parameter int BANK_BYTES   = xcfr_pkg::BANK_BYTES_DEF,
   parameter int HEADER_BYTES = xcfr_pkg::HEADER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   xcfr_req_if.sink   req_chan,
   xcfr_rsp_if.source rsp_chan
);

   localparam int ADDR_W  = $clog2(2 * BANK_BYTES);
   localparam int LEN_MAX = BANK_BYTES - HEADER_BYTES - 1;
   localparam int LW      = xcfr_pkg::LEN_W;

   xcfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    start_byte_ff;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    decl_len_ff, decl_len_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;
   logic          ready_ff, ready_in;
   logic [LW-1:0] good_len_ff, good_len_in;

   logic          rsp_valid_ff;
   logic [2:0]    ev_ff;
   logic          frame_ready_ff;
   logic [LW-1:0] frame_len_ff;
   logic          rd_sel_ff;

   logic          accept;
   logic          is_byte;
   logic          start_hit;
   logic          len_bad;
   logic [LW-1:0] fill_inc;
   logic [LW-1:0] load_end;
   logic [2:0]    ev;
   logic          put;
   logic [LW-1:0] put_pos;
   logic          wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic          rd_hit;
   logic          rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_byte   = (req_chan.req_type == xcfr_pkg::REQ_BYTE);
   assign start_hit = (req_chan.rx_byte == start_byte_ff);
   assign len_bad   = (req_chan.rx_byte == 8'd0) || (int'(req_chan.rx_byte) > LEN_MAX);
   assign fill_inc  = fill_ff + LW'(1);
   assign load_end  = {1'b0, decl_len_ff} + LW'(HEADER_BYTES);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_byte) begin
         case (phase_ff)
            xcfr_pkg::PH_HUNT: begin
               if (start_hit) begin
                  phase_in = (HEADER_BYTES <= 1) ? xcfr_pkg::PH_LOAD : xcfr_pkg::PH_HEAD;
               end
            end
            xcfr_pkg::PH_HEAD: begin
               if (fill_ff == LW'(1) && len_bad) begin
                  phase_in = xcfr_pkg::PH_HUNT;
               end else if (int'(fill_inc) >= HEADER_BYTES) begin
                  phase_in = xcfr_pkg::PH_LOAD;
               end
            end
            xcfr_pkg::PH_LOAD: begin
               if (fill_inc >= load_end) begin
                  phase_in = xcfr_pkg::PH_SUM;
               end
            end
            xcfr_pkg::PH_SUM: phase_in = xcfr_pkg::PH_HUNT;
            default: phase_in = xcfr_pkg::PH_HUNT;
         endcase
      end
   end

   // datapath and event
   always_comb begin
      xor_in      = xor_ff;
      decl_len_in = decl_len_ff;
      fill_in     = fill_ff;
      bank_in     = bank_ff;
      ready_in    = ready_ff;
      good_len_in = good_len_ff;
      ev          = xcfr_pkg::EV_IGNORED;
      put         = 1'b0;
      put_pos     = fill_ff;
      if (is_byte) begin
         case (phase_ff)
            xcfr_pkg::PH_HUNT: begin
               put_pos = '0;
               if (start_hit) begin
                  ev      = xcfr_pkg::EV_TAKEN;
                  put     = 1'b1;
                  xor_in  = req_chan.rx_byte;
                  fill_in = LW'(1);
               end
            end
            xcfr_pkg::PH_HEAD: begin
               if (fill_ff == LW'(1)) begin
                  decl_len_in = req_chan.rx_byte;
               end
               if (fill_ff == LW'(1) && len_bad) begin
                  ev = xcfr_pkg::EV_LEN_ERR;
               end else begin
                  ev      = xcfr_pkg::EV_TAKEN;
                  put     = 1'b1;
                  xor_in  = xor_ff ^ req_chan.rx_byte;
                  fill_in = fill_inc;
               end
            end
            xcfr_pkg::PH_LOAD: begin
               ev      = xcfr_pkg::EV_TAKEN;
               put     = 1'b1;
               xor_in  = xor_ff ^ req_chan.rx_byte;
               fill_in = fill_inc;
            end
            xcfr_pkg::PH_SUM: begin
               put     = 1'b1;
               fill_in = fill_inc;
               if (xor_ff == req_chan.rx_byte) begin
                  ev          = xcfr_pkg::EV_GOOD;
                  bank_in     = !bank_ff;
                  ready_in    = 1'b1;
                  good_len_in = fill_inc;
               end else begin
                  ev = xcfr_pkg::EV_BAD_SUM;
               end
            end
            default: ev = xcfr_pkg::EV_IGNORED;
         endcase
      end else if (req_chan.req_type == xcfr_pkg::REQ_CLEAR) begin
         ready_in = 1'b0;
      end
   end

   // frames fill the bank that is not holding the completed frame
   assign wr_en   = accept && put && (int'(put_pos) < BANK_BYTES);
   assign wr_addr = ADDR_W'(int'(put_pos) + (bank_ff ? 0 : BANK_BYTES));

   assign rd_hit  = (req_chan.req_type == xcfr_pkg::REQ_READ)
                    && ({1'b0, req_chan.read_index} < good_len_ff)
                    && (int'(req_chan.read_index) < BANK_BYTES);
   assign rd_en   = accept && rd_hit;
   assign rd_addr = ADDR_W'(int'(req_chan.read_index) + (bank_ff ? BANK_BYTES : 0));

   xcfr_frame_ram #(
      .DEPTH  (2 * BANK_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_chan.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= xcfr_pkg::START_BYTE_RST;
      end else if (csr_wr_en) begin
         start_byte_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= xcfr_pkg::PH_HUNT;
         xor_ff      <= '0;
         decl_len_ff <= '0;
         fill_ff     <= '0;
         bank_ff     <= 1'b0;
         ready_ff    <= 1'b0;
         good_len_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         xor_ff      <= xor_in;
         decl_len_ff <= decl_len_in;
         fill_ff     <= fill_in;
         bank_ff     <= bank_in;
         ready_ff    <= ready_in;
         good_len_ff <= good_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ev_ff          <= ev;
         frame_ready_ff <= ready_in;
         frame_len_ff   <= good_len_in;
         rd_sel_ff      <= rd_hit;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_res    = ev_ff;
   assign rsp_chan.frame_ready  = frame_ready_ff;
   assign rsp_chan.frame_length = frame_len_ff;
   assign rsp_chan.read_data    = rd_sel_ff ? rd_data : 8'd0;

   // writes never land in the bank that holds the completed frame
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (bank_ff ? (int'(wr_addr) < BANK_BYTES) : (int'(wr_addr) >= BANK_BYTES)))
      else $error("frame write into completed bank");

   // checksum phase is reached exactly when the declared frame is stored
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == xcfr_pkg::PH_SUM) |-> (fill_ff == load_end))
      else $error("checksum phase with wrong fill count");

   // a good frame swaps the banks
   assert property (@(posedge clock) disable iff (reset)
      (accept && ev == xcfr_pkg::EV_GOOD) |=> (bank_ff != $past(bank_ff)))
      else $error("good frame without bank swap");

   // a good frame result always reports the ready flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ev_ff == xcfr_pkg::EV_GOOD) |-> frame_ready_ff)
      else $error("good frame reported without ready flag");

   // a read result only comes with an ignored event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rd_sel_ff) |-> (ev_ff == xcfr_pkg::EV_IGNORED))
      else $error("read result with nonzero event");

endmodule

// ===== verif/xor_checked_frame_receiver_top_test.sv =====
module xor_checked_frame_receiver_top_test;
   import xcfr_pkg::*;

   localparam int HDR     = HEADER_BYTES_DEF;
   localparam int MAX_LEN = BANK_BYTES_DEF - HEADER_BYTES_DEF - 1;
   localparam int N_ROWS  = 25;
   localparam int N_PHASE = 6;

   // request code the block does not define
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [2:0] event_res;
      logic       frame_ready;
      logic [8:0] frame_length;
      logic [7:0] read_data;
   } frame_result_t;

   typedef struct packed {
      logic [1:0]    kind;
      logic [7:0]    data;
      logic [7:0]    index;
      bit            typed;
      frame_result_t want;
   } stim_row_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   xcfr_req_if req_chan ();
   xcfr_rsp_if rsp_chan ();

   xor_checked_frame_receiver_top dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan)
   );

   // receiver state as the testbench sees it
   phase_type  rx_state;
   logic [7:0] xor_acc;
   logic [7:0] len_field;
   logic [7:0] sof_byte;
   logic [8:0] byte_count;
   logic [8:0] kept_length;
   logic       done_bank;
   logic       ready_bit;
   logic [7:0] bank_mem [0:2*BANK_BYTES_DEF-1];

   frame_result_t pending_results [$];
   stim_row_t     directed_rows [N_ROWS];
   int            error_count = 0;
   int            items_sent  = 0;
   int            idle_odds   = 5;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL xor_checked_frame_receiver_top");
      $finish;
   end

   function automatic void store_byte(logic [7:0] b);
      if (byte_count < 9'(BANK_BYTES_DEF)) bank_mem[{~done_bank, byte_count[7:0]}] = b;
      byte_count = byte_count + 9'd1;
   endfunction

   function automatic frame_result_t next_frame_result(logic [1:0] kind, logic [7:0] b,
                                                       logic [7:0] idx);
      frame_result_t r;
      r = '0;
      r.event_res = EV_IGNORED;
      case (kind)
         REQ_BYTE: begin
            case (rx_state)
               PH_HUNT: if (b == sof_byte) begin
                  byte_count = 9'd0;
                  store_byte(b);
                  xor_acc = b;
                  rx_state = (byte_count >= HDR) ? PH_LOAD : PH_HEAD;
                  r.event_res = EV_TAKEN;
               end
               PH_HEAD: begin
                  if (byte_count == 9'd1) len_field = b;
                  // zero length or a frame that would not fit a bank
                  if (byte_count == 9'd1 && (b == 8'd0 || int'(b) > MAX_LEN)) begin
                     rx_state = PH_HUNT;
                     r.event_res = EV_LEN_ERR;
                  end else begin
                     xor_acc ^= b;
                     store_byte(b);
                     if (byte_count >= HDR) rx_state = PH_LOAD;
                     r.event_res = EV_TAKEN;
                  end
               end
               PH_LOAD: begin
                  xor_acc ^= b;
                  store_byte(b);
                  if (int'(byte_count) >= int'(len_field) + HDR) rx_state = PH_SUM;
                  r.event_res = EV_TAKEN;
               end
               PH_SUM: begin
                  store_byte(b);
                  if (xor_acc == b) begin
                     done_bank = ~done_bank;
                     ready_bit = 1'b1;
                     kept_length = byte_count;
                     r.event_res = EV_GOOD;
                  end else begin
                     r.event_res = EV_BAD_SUM;
                  end
                  rx_state = PH_HUNT;
               end
            endcase
         end
         REQ_READ: if (idx < kept_length) r.read_data = bank_mem[{done_bank, idx}];
         REQ_CLEAR: ready_bit = 1'b0;
         default: ;
      endcase
      r.frame_ready = ready_bit;
      r.frame_length = kept_length;
      return r;
   endfunction

   function automatic stim_row_t stim_row(logic [1:0] kind, logic [7:0] data, logic [7:0] index,
                                          bit typed, logic [2:0] ev, logic rdy,
                                          logic [8:0] len, logic [7:0] rd);
      stim_row_t s;
      s.kind = kind;
      s.data = data;
      s.index = index;
      s.typed = typed;
      s.want.event_res = ev;
      s.want.frame_ready = rdy;
      s.want.frame_length = len;
      s.want.read_data = rd;
      return s;
   endfunction

   // valid stays high when the next request follows without a gap
   task automatic send_request(input logic [1:0] kind, input logic [7:0] data,
                               input logic [7:0] index, input bit typed,
                               input frame_result_t want);
      frame_result_t predicted;
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.rx_byte    <= data;
      req_chan.read_index <= index;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = next_frame_result(kind, data, index);
      pending_results.push_back(typed ? want : predicted);
      if (kind != REQ_UNUSED && !(kind == REQ_BYTE && predicted.event_res == EV_IGNORED))
         items_sent++;
      if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [7:0] len_byte, input bit corrupt, input bit broken);
      logic [7:0] sum;
      logic [7:0] b;
      int total;
      int sum_pos;
      sum_pos = int'(len_byte) + HDR;
      total = (len_byte == 8'd0 || int'(len_byte) > MAX_LEN) ? 2 : sum_pos + 1;
      if (broken) total = $urandom_range(1, total - 1);
      sum = 8'h00;
      for (int i = 0; i < total; i++) begin
         if (i == 0) b = sof_byte;
         else if (i == 1) b = len_byte;
         else if (i == sum_pos) b = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
         else b = 8'($urandom);
         sum ^= b;
         send_request(REQ_BYTE, b, 8'($urandom), 1'b0, '0);
      end
   endtask

   task automatic set_start_byte(input logic [7:0] v);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sof_byte = v;
   endtask

   // result side: ready drops in random bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(0, 11)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      frame_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_chan.event_res);
               error_count++;
            end
            if (rsp_chan.frame_ready !== want.frame_ready) begin
               $error("frame_ready: expected %0d, got %0d", want.frame_ready,
                      rsp_chan.frame_ready);
               error_count++;
            end
            if (rsp_chan.frame_length !== want.frame_length) begin
               $error("frame_length: expected %0d, got %0d", want.frame_length,
                      rsp_chan.frame_length);
               error_count++;
            end
            if (rsp_chan.read_data !== want.read_data) begin
               $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                      rsp_chan.read_data);
               error_count++;
            end
         end
      end
   end

   initial begin
      int n;
      int pick;
      logic [7:0] idx;
      logic [7:0] len_byte;
      logic [7:0] sof_next;

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= 8'h00;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_BYTE;
      req_chan.rx_byte    <= 8'h00;
      req_chan.read_index <= 8'h00;

      rx_state    = PH_HUNT;
      xor_acc     = 8'h00;
      len_field   = 8'h00;
      sof_byte    = START_BYTE_RST;
      byte_count  = 9'd0;
      kept_length = 9'd0;
      done_bank   = 1'b0;
      ready_bit   = 1'b0;
      foreach (bank_mem[i]) bank_mem[i] = 8'h00;

      // stray requests, length errors, a minimal good frame: length one, checksum 0x24, reads, a clear
      directed_rows = '{
         stim_row(REQ_READ,   8'h00, 8'h00, 1, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_CLEAR,  8'h00, 8'h00, 1, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_UNUSED, 8'hFF, 8'hFF, 1, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h00, 8'h00, 1, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hFF, 8'h00, 1, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hFC, 8'h00, 1, EV_TAKEN,   0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h00, 8'h00, 1, EV_LEN_ERR, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hFC, 8'h00, 1, EV_TAKEN,   0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hF8, 8'h00, 1, EV_LEN_ERR, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hFC, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h01, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h00, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hFF, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h55, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hAA, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h12, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h34, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'hFF, 8'h00, 0, EV_IGNORED, 0, 9'd0,  8'h00),
         stim_row(REQ_BYTE,   8'h24, 8'h00, 1, EV_GOOD,    1, 9'd10, 8'h00),
         stim_row(REQ_READ,   8'h00, 8'h00, 1, EV_IGNORED, 1, 9'd10, 8'hFC),
         stim_row(REQ_READ,   8'h00, 8'h09, 1, EV_IGNORED, 1, 9'd10, 8'h24),
         stim_row(REQ_READ,   8'h00, 8'h0A, 1, EV_IGNORED, 1, 9'd10, 8'h00),
         stim_row(REQ_READ,   8'h00, 8'hFF, 1, EV_IGNORED, 1, 9'd10, 8'h00),
         stim_row(REQ_CLEAR,  8'h00, 8'h00, 1, EV_IGNORED, 0, 9'd10, 8'h00),
         stim_row(REQ_READ,   8'h00, 8'h08, 0, EV_IGNORED, 0, 9'd0,  8'h00)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_ROWS; i++)
         send_request(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].index,
                      directed_rows[i].typed, directed_rows[i].want);

      // full-bank frame, a read of its last byte, then a bad checksum
      send_frame(8'(MAX_LEN), 1'b0, 1'b0);
      send_request(REQ_READ, 8'h00, 8'hFF, 1'b0, '0);
      send_frame(8'd1, 1'b1, 1'b0);

      for (int p = 0; p < N_PHASE; p++) begin
         case (p)
            0: idle_odds = 4;
            1: idle_odds = 2;
            2: idle_odds = 0;
            3: idle_odds = 10;
            4: idle_odds = 3;
            default: idle_odds = 0;
         endcase
         case (p)
            1: sof_next = 8'h00;
            2: sof_next = 8'hFF;
            5: sof_next = START_BYTE_RST;
            default: sof_next = 8'($urandom);
         endcase
         if (p != 0) set_start_byte(sof_next);

         while (items_sent < (p + 1) * 225) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
               n = $urandom_range(99);
               if (n < 5)
                  len_byte = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(MAX_LEN + 1, 255));
               else if (n < 7)
                  len_byte = ($urandom_range(1) == 0) ? 8'(MAX_LEN)
                                                      : 8'($urandom_range(100, MAX_LEN));
               else
                  len_byte = 8'($urandom_range(1, 24));
               send_frame(len_byte, $urandom_range(5) == 0, $urandom_range(9) == 0);
            end else if (pick < 80) begin
               n = $urandom_range(1, 4);
               repeat (n) begin
                  if (kept_length != 9'd0 && $urandom_range(3) != 0)
                     idx = 8'($urandom_range(int'(kept_length) - 1));
                  else
                     idx = 8'($urandom);
                  send_request(REQ_READ, 8'($urandom), idx, 1'b0, '0);
               end
            end else if (pick < 87) begin
               send_request(REQ_CLEAR, 8'($urandom), 8'($urandom), 1'b0, '0);
            end else if (pick < 95) begin
               send_request(REQ_BYTE, 8'($urandom), 8'($urandom), 1'b0, '0);
            end else begin
               send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), 1'b0, '0);
            end
         end
      end

      req_chan.valid <= 1'b0;
      for (int w = 0; w < 500 && pending_results.size() != 0; w++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         error_count++;
      end

      if (error_count == 0)
         $display("PASS xor_checked_frame_receiver_top");
      else
         $display("FAIL xor_checked_frame_receiver_top");
      $finish;
   end

endmodule
